/* sv/bdlp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdlp_pkg
// Shared widths, reset values, register indexes and lane interface types
// of the button debouncer with long-press detection.
// ----------------------------------------------------------------------------
package bdlp_pkg;

	localparam int FIELD_W         = 4;   // width of every mask field
	localparam int STAMP_W         = 32;  // millisecond timestamp width
	localparam int TIME_W          = 16;  // width of the time registers
	localparam int NUM_BUTTONS_DEF = 4;

	localparam int IN_DATA_W  = 48;       // 44 bits of fields, padded to bytes
	localparam int OUT_DATA_W = 16;       // 12 bits of fields, padded to bytes

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TIME   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TIME = 1'b1;

	localparam logic [TIME_W-1:0] DEBOUNCE_RST   = 16'd50;
	localparam logic [TIME_W-1:0] LONG_PRESS_RST = 16'd1000;

	typedef struct packed {
		logic [TIME_W-1:0] debounce_time;
		logic [TIME_W-1:0] long_press_time;
	} cfg_t;

	typedef struct packed {
		logic lvl;        // raw level, 1 released
		logic ack_press;
		logic ack_long;
	} lane_in_t;

	typedef struct packed {
		logic held;
		logic press;
		logic lng;
	} lane_res_t;

endpackage
`default_nettype wire

/* sv/bdlp_lane.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdlp_lane
// Debounce and long-press core for one button. Reports the updated state
// combinationally and commits it, with acknowledges applied, on a transaction.
// ----------------------------------------------------------------------------
module bdlp_lane (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire bdlp_pkg::cfg_t               cfg,
	input  wire logic [bdlp_pkg::STAMP_W-1:0] now_ms,
	input  wire bdlp_pkg::lane_in_t           lane_in,
	output bdlp_pkg::lane_res_t               res
);

	logic                         last_q;
	logic                         stable_q;
	logic                         press_q;
	logic                         long_q;
	logic [bdlp_pkg::STAMP_W-1:0] change_q;
	logic [bdlp_pkg::STAMP_W-1:0] pstamp_q;

	logic [bdlp_pkg::STAMP_W-1:0] change_d;
	logic [bdlp_pkg::STAMP_W-1:0] pstamp_d;
	logic [bdlp_pkg::STAMP_W-1:0] since_change;
	logic [bdlp_pkg::STAMP_W-1:0] since_press;
	logic                         upd;
	logic                         fall;
	logic                         stable_d;
	logic                         press_d;
	logic                         long_a;
	logic                         long_d;

	always_comb begin
		change_d     = (lane_in.lvl != last_q) ? now_ms : change_q;
		since_change = now_ms - change_d;
		upd          = (since_change >=
		                {{(bdlp_pkg::STAMP_W-bdlp_pkg::TIME_W){1'b0}}, cfg.debounce_time})
		               && (lane_in.lvl != stable_q);
		fall         = upd && !lane_in.lvl;
		stable_d     = upd ? lane_in.lvl : stable_q;
		press_d      = upd ? !lane_in.lvl : press_q;
		pstamp_d     = fall ? now_ms : pstamp_q;
		long_a       = fall ? 1'b0 : long_q;
		since_press  = now_ms - pstamp_d;
		long_d       = long_a;
		if (!stable_d && !long_a && (since_press >=
		    {{(bdlp_pkg::STAMP_W-bdlp_pkg::TIME_W){1'b0}}, cfg.long_press_time}))
			long_d = 1'b1;
	end

	assign res.held  = !stable_d;
	assign res.press = press_d;
	assign res.lng   = long_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q   <= 1'b1;
			stable_q <= 1'b1;
			press_q  <= 1'b0;
			long_q   <= 1'b0;
			change_q <= '0;
			pstamp_q <= '0;
		end else if (en) begin
			last_q   <= lane_in.lvl;
			stable_q <= stable_d;
			press_q  <= press_d & ~lane_in.ack_press;
			long_q   <= long_d & ~lane_in.ack_long;
			change_q <= change_d;
			pstamp_q <= pstamp_d;
		end
	end

endmodule
`default_nettype wire

/* sv/bdlp_merge.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdlp_merge
// Gathers the lane results into the three masks and holds them in the
// output register until the downstream side takes the transaction.
// ----------------------------------------------------------------------------
module bdlp_merge #(
	parameter int NUM_BUTTONS = bdlp_pkg::NUM_BUTTONS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            load,
	input  wire bdlp_pkg::lane_res_t             res [NUM_BUTTONS],
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [bdlp_pkg::OUT_DATA_W-1:0]      m_tdata
);

	logic [bdlp_pkg::FIELD_W-1:0] held_m;
	logic [bdlp_pkg::FIELD_W-1:0] press_m;
	logic [bdlp_pkg::FIELD_W-1:0] long_m;
	logic [bdlp_pkg::FIELD_W-1:0] held_q;
	logic [bdlp_pkg::FIELD_W-1:0] press_q;
	logic [bdlp_pkg::FIELD_W-1:0] long_q;
	logic                         valid_q;

	// buttons past the field width are dropped from the masks
	for (genvar i = 0; i < bdlp_pkg::FIELD_W; i++) begin : g_bit
		if (i < NUM_BUTTONS) begin : g_lane
			assign held_m[i]  = res[i].held;
			assign press_m[i] = res[i].press;
			assign long_m[i]  = res[i].lng;
		end else begin : g_none
			assign held_m[i]  = 1'b0;
			assign press_m[i] = 1'b0;
			assign long_m[i]  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			held_q  <= held_m;
			press_q <= press_m;
			long_q  <= long_m;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {{(bdlp_pkg::OUT_DATA_W-3*bdlp_pkg::FIELD_W){1'b0}},
	                   long_q, press_q, held_q};

endmodule
`default_nettype wire

/* sv/button_debounce_long_press.sv */
`timescale 1ns / 1ps
`default_nettype none
// An input transaction's result is in the output register in the cycle after it.
// Throughput: one sample per cycle while unstalled; all button lanes update in
// parallel in the cycle of the transaction, set by one lane's two chained
// subtract-and-compare steps. Input is taken while the output register is empty
// or being drained. Reset (arst_n low): buttons released, stamps and flags zero,
// debounce 50 ms, long press 1000 ms, output register empty.
// ----------------------------------------------------------------------------
// button_debounce_long_press
// Multi-button debouncer with sticky press and long-press flags, one
// lane per button and a merging output stage.
// ----------------------------------------------------------------------------
module button_debounce_long_press #(
	parameter int NUM_BUTTONS = bdlp_pkg::NUM_BUTTONS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration write port
	input  wire logic                            cfg_we,
	input  wire logic [bdlp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bdlp_pkg::TIME_W-1:0]     cfg_data,
	// sample stream
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// from bit 0: raw_levels[3:0], now_ms[35:4], ack_press[39:36],
	// ack_long[43:40], zero pad
	input  wire logic [bdlp_pkg::IN_DATA_W-1:0]  s_tdata,
	// result stream
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// from bit 0: held_mask[3:0], press_mask[7:4], long_mask[11:8], zero pad
	output logic [bdlp_pkg::OUT_DATA_W-1:0]      m_tdata
);

	localparam int NOW_LSB  = bdlp_pkg::FIELD_W;
	localparam int ACKP_LSB = NOW_LSB + bdlp_pkg::STAMP_W;
	localparam int ACKL_LSB = ACKP_LSB + bdlp_pkg::FIELD_W;

	bdlp_pkg::cfg_t      cfg_q;
	bdlp_pkg::lane_res_t res [NUM_BUTTONS];
	logic                accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_time   <= bdlp_pkg::DEBOUNCE_RST;
			cfg_q.long_press_time <= bdlp_pkg::LONG_PRESS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bdlp_pkg::REG_DEBOUNCE_TIME:   cfg_q.debounce_time   <= cfg_data;
				bdlp_pkg::REG_LONG_PRESS_TIME: cfg_q.long_press_time <= cfg_data;
				default: ;
			endcase
		end
	end

	assign s_tready = !m_tvalid || m_tready;
	assign accept   = s_tvalid && s_tready;

	for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
		bdlp_pkg::lane_in_t lane_in;

		// buttons past the field width read as pressed and see no acknowledge
		if (i < bdlp_pkg::FIELD_W) begin : g_field
			assign lane_in.lvl       = s_tdata[i];
			assign lane_in.ack_press = s_tdata[ACKP_LSB + i];
			assign lane_in.ack_long  = s_tdata[ACKL_LSB + i];
		end else begin : g_extra
			assign lane_in.lvl       = 1'b0;
			assign lane_in.ack_press = 1'b0;
			assign lane_in.ack_long  = 1'b0;
		end

		bdlp_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (accept),
			.cfg     (cfg_q),
			.now_ms  (s_tdata[NOW_LSB +: bdlp_pkg::STAMP_W]),
			.lane_in (lane_in),
			.res     (res[i])
		);
	end

	bdlp_merge #(
		.NUM_BUTTONS (NUM_BUTTONS)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.res      (res),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// a result waiting with no taker must stall the input side
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tvalid && s_tready && m_tvalid && !m_tready))
		else $error("input accepted over a stalled result");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> m_tvalid)
		else $error("accepted sample produced no result");

	// a press flag only survives while the button is held
	a_press_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[2*bdlp_pkg::FIELD_W-1:bdlp_pkg::FIELD_W]
		               & ~m_tdata[bdlp_pkg::FIELD_W-1:0]) == '0))
		else $error("press flag set on a released button");

endmodule
`default_nettype wire

/* test/button_debounce_long_press_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_long_press_tb
// Streams timestamped button samples into the debouncer and checks every
// held/press/long mask set against a cycle-free predictor of the per-button
// debounce and long-press logic, under several timing register settings
// and with random stalls on both stream sides.
// ----------------------------------------------------------------------------
module button_debounce_long_press_tb;
	import bdlp_pkg::*;

	localparam int NB          = NUM_BUTTONS_DEF;
	localparam int HOLD_CYCLES = 400;
	localparam int STUCK_LIMIT = 4000;

	typedef struct packed {
		logic [FIELD_W-1:0] ack_long;
		logic [FIELD_W-1:0] ack_press;
		logic [STAMP_W-1:0] now;
		logic [FIELD_W-1:0] raw;
	} sample_t;

	typedef struct packed {
		logic [FIELD_W-1:0] lng;
		logic [FIELD_W-1:0] press;
		logic [FIELD_W-1:0] held;
	} masks_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [TIME_W-1:0]     cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// raw_levels, now_ms, ack_press, ack_long, zero pad (from bit 0)
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// held_mask, press_mask, long_mask, zero pad (from bit 0)
	logic [OUT_DATA_W-1:0] m_tdata;

	button_debounce_long_press #(.NUM_BUTTONS(NB)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// predictor copy of the timing registers and per-button state
	logic [TIME_W-1:0]  deb_ms = DEBOUNCE_RST;
	logic [TIME_W-1:0]  long_ms = LONG_PRESS_RST;
	logic               last_lvl[NB] = '{default: 1'b1};
	logic               stable_lvl[NB] = '{default: 1'b1};
	logic [STAMP_W-1:0] change_at[NB] = '{default: '0};
	logic [STAMP_W-1:0] press_at[NB] = '{default: '0};
	logic               press_flag[NB] = '{default: 1'b0};
	logic               long_flag[NB] = '{default: 1'b0};

	sample_t     samples_to_send[$];
	masks_t      masks_due[$];
	sample_t     on_bus;
	logic [FIELD_W-1:0] want_lvl = '1;
	logic [STAMP_W-1:0] t_now = '0;

	int          src_idle_pct = 0;
	int          snk_idle_pct = 0;
	logic        hold_req = 1'b0;
	logic        hold_ack = 1'b0;
	int          hold_left = 0;
	int          stuck_cycles = 0;
	int unsigned mismatches = 0;
	int unsigned samples_taken = 0;
	int unsigned masks_checked = 0;
	int unsigned press_seen = 0;
	int unsigned long_seen = 0;
	int unsigned settings_used = 1;

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic masks_t debounce_update(input sample_t s);
		masks_t             r;
		logic [STAMP_W-1:0] since_change;
		logic [STAMP_W-1:0] since_press;
		r = '0;
		for (int b = 0; b < NB; b++) begin
			if (s.raw[b] != last_lvl[b])
				change_at[b] = s.now;
			since_change = s.now - change_at[b];
			if (since_change >= {16'b0, deb_ms} && s.raw[b] != stable_lvl[b]) begin
				stable_lvl[b] = s.raw[b];
				if (!s.raw[b]) begin
					press_flag[b] = 1'b1;
					press_at[b] = s.now;
					long_flag[b] = 1'b0;
				end else begin
					press_flag[b] = 1'b0;
				end
			end
			since_press = s.now - press_at[b];
			if (!stable_lvl[b] && !long_flag[b] && since_press >= {16'b0, long_ms})
				long_flag[b] = 1'b1;
			last_lvl[b] = s.raw[b];
			r.held[b] = !stable_lvl[b];
			r.press[b] = press_flag[b];
			r.lng[b] = long_flag[b];
			// acks clear only after the flags have been reported
			if (s.ack_press[b])
				press_flag[b] = 1'b0;
			if (s.ack_long[b])
				long_flag[b] = 1'b0;
		end
		return r;
	endfunction

	task automatic check_masks(input logic [OUT_DATA_W-1:0] d);
		masks_t want;
		if (masks_due.size() == 0) begin
			$error("result %h arrived with no sample outstanding", d);
			mismatches++;
		end else begin
			want = masks_due.pop_front();
			masks_checked++;
			if (d[3:0] != 0 || d[7:4] != 0) press_seen += (d[7:4] != 0);
			if (d[11:8] != 0) long_seen++;
			if (d[3:0] !== want.held) begin
				$error("held_mask: expected %h, actual %h", want.held, d[3:0]);
				mismatches++;
			end
			if (d[7:4] !== want.press) begin
				$error("press_mask: expected %h, actual %h", want.press, d[7:4]);
				mismatches++;
			end
			if (d[11:8] !== want.lng) begin
				$error("long_mask: expected %h, actual %h", want.lng, d[11:8]);
				mismatches++;
			end
		end
	endtask

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				masks_due.push_back(debounce_update(on_bus));
				samples_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (samples_to_send.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					on_bus = samples_to_send.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {4'b0, on_bus.ack_long, on_bus.ack_press, on_bus.now, on_bus.raw};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor; a toggle of hold_req starts a long hold-off of tready
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				check_masks(m_tdata);
			if (hold_ack != hold_req) begin
				hold_ack <= hold_req;
				hold_left <= HOLD_CYCLES;
				m_tready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	// watchdog: only counts while work is outstanding
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
		    (samples_to_send.size() == 0 && masks_due.size() == 0 && !s_tvalid)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles == STUCK_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	task automatic queue_sample(input logic [FIELD_W-1:0] raw, input logic [STAMP_W-1:0] now,
			input logic [FIELD_W-1:0] ackp, input logic [FIELD_W-1:0] ackl);
		sample_t s;
		s.raw = raw;
		s.now = now;
		s.ack_press = ackp;
		s.ack_long = ackl;
		samples_to_send.push_back(s);
	endtask

	// buttons follow slowly changing intents with occasional bounce glitches
	task automatic queue_random(input int n, input int dt_max);
		sample_t s;
		for (int k = 0; k < n; k++) begin
			for (int b = 0; b < NB; b++)
				if ($urandom_range(24) == 0)
					want_lvl[b] = ~want_lvl[b];
			s.raw = want_lvl;
			if ($urandom_range(9) == 0)
				s.raw[$urandom_range(NB - 1)] ^= 1'b1;
			case ($urandom_range(49))
				0: t_now = $urandom();
				1: t_now = t_now - $urandom_range(dt_max);
				default: t_now = t_now + $urandom_range(dt_max);
			endcase
			s.now = t_now;
			s.ack_press = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'h0;
			s.ack_long = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'h0;
			samples_to_send.push_back(s);
		end
	endtask

	// results are registered, so drain waits past the emptied queues to settle the block
	task automatic drain();
		@(negedge clk);
		while (samples_to_send.size() != 0 || masks_due.size() != 0 || s_tvalid)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_DEBOUNCE_TIME:   deb_ms = val;
			REG_LONG_PRESS_TIME: long_ms = val;
			default: ;
		endcase
	endtask

	initial begin
		int deb_set[6]  = '{10, 0, 65535, 3, 1, 65535};
		int long_set[6] = '{100, 0, 65535, 40, 65535, 0};
		int dt_set[6]   = '{8, 5, 8000, 6, 4, 8000};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		src_idle_pct = 11;
		snk_idle_pct = 52;

		// reset timing: 50 ms debounce, 1000 ms long press
		queue_sample(4'hF, 32'd0, 4'h0, 4'h0);
		queue_sample(4'hE, 32'd10, 4'h0, 4'h0);
		queue_sample(4'hE, 32'd59, 4'h0, 4'h0);     // one ms short of stable
		queue_sample(4'hE, 32'd60, 4'h0, 4'h0);     // press
		queue_sample(4'hE, 32'd1059, 4'h0, 4'h0);
		queue_sample(4'hE, 32'd1060, 4'h0, 4'h0);   // long press
		queue_sample(4'hE, 32'd1061, 4'h0, 4'h1);   // long acked while held
		queue_sample(4'hE, 32'd1062, 4'h0, 4'h0);   // ... comes back
		queue_sample(4'hE, 32'd1063, 4'h1, 4'h0);   // press acked while held
		queue_sample(4'hE, 32'd1064, 4'h0, 4'h0);   // ... stays clear
		queue_sample(4'h0, 32'hFFFF_FFF0, 4'h0, 4'h0);
		queue_sample(4'h0, 32'h0000_0030, 4'h0, 4'h0); // wraps past zero
		queue_sample(4'h0, 32'h0000_0020, 4'hF, 4'hF); // time goes backwards
		queue_sample(4'hF, 32'h0000_0021, 4'h0, 4'h0);
		queue_sample(4'hF, 32'hFFFF_FFFF, 4'h0, 4'h0);
		drain();

		// zero timing: stable and long on the very step of the change
		write_reg(REG_DEBOUNCE_TIME, 16'd0);
		write_reg(REG_LONG_PRESS_TIME, 16'd0);
		settings_used++;
		queue_sample(4'h5, 32'hFFFF_FFFF, 4'h0, 4'h0);
		queue_sample(4'hA, 32'd0, 4'hF, 4'hF);
		queue_sample(4'hF, 32'd0, 4'h0, 4'h0);
		queue_sample(4'h0, 32'd0, 4'hF, 4'h0);
		queue_sample(4'h0, 32'd0, 4'h0, 4'hF);
		queue_sample(4'h0, 32'd0, 4'h0, 4'h0);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 2) begin
				src_idle_pct = 52;
				snk_idle_pct = 11;
			end else if (ph == 4) begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			write_reg(REG_DEBOUNCE_TIME, TIME_W'(deb_set[ph]));
			write_reg(REG_LONG_PRESS_TIME, TIME_W'(long_set[ph]));
			settings_used++;
			t_now = (ph == 3) ? 32'hFFFF_FF00 : $urandom();
			queue_random(210, dt_set[ph]);
			// back-pressure: stall the result side while samples keep coming
			if (ph == 0)
				hold_req = ~hold_req;
			drain();
		end

		$display("%0d samples over %0d timing settings, %0d mask sets checked, %0d mismatches",
			samples_taken, settings_used, masks_checked, mismatches);
		$display("%0d results reported a press flag, %0d a long-press flag",
			press_seen, long_seen);
		if (mismatches == 0 && masks_due.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
